### src/vsc_pkg.sv
// shared types, codes and helpers for the vigenere stream cipher
package vsc_pkg;

  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_TAB   = 8'h09;

  localparam int KEY_LENGTH_W = 7;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic REG_KEY_LENGTH  = 1'b0;
  localparam logic REG_DECRYPT_MODE = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       is_key;
    logic       start;
    logic       blank;
    logic       byte_ok;
    logic [7:0] value;
    logic [5:0] slot;
  } vsc_item_t;

  function automatic logic in_alphabet(input logic [7:0] code, input logic [7:0] first,
                                       input logic [8:0] size);
    logic [8:0] diff;
    diff = {1'b0, code} - {1'b0, first};
    return (code >= first) && (diff < size);
  endfunction

endpackage

### src/vsc_ram.sv
// generic single write port ram with registered read
module vsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/vsc_front.sv
// input side: accepts items and classifies them before queuing
module vsc_front
  import vsc_pkg::*;
#(
  parameter int ALPHABET_SIZE = 95,
  parameter int FIRST_CHAR    = 32
) (
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_kind,
  input  logic [7:0] in_byte_value,
  input  logic [5:0] in_key_slot,
  input  logic      in_message_start,
  input  logic      q_full,
  output logic      q_push,
  output vsc_item_t q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    q_item.is_key  = in_kind;
    q_item.start   = in_message_start & ~in_kind;
    q_item.blank   = (in_byte_value == CODE_SPACE) || (in_byte_value == CODE_TAB);
    q_item.byte_ok = in_alphabet(in_byte_value, 8'(FIRST_CHAR), 9'(ALPHABET_SIZE));
    q_item.value   = in_byte_value;
    q_item.slot    = in_key_slot;
  end

endmodule

### src/vsc_queue.sv
// short item queue between front and back
module vsc_queue
  import vsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  vsc_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output vsc_item_t head_item
);

  vsc_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/vsc_back.sv
// back side: key store, key position tracking, cipher and output register
module vsc_back
  import vsc_pkg::*;
#(
  parameter int ALPHABET_SIZE = 95,
  parameter int FIRST_CHAR    = 32,
  parameter int KEY_DEPTH     = 64,
  parameter int PW            = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  vsc_item_t   head_item,
  output logic        pop,
  input  logic [PW:0] key_len,
  input  logic        decrypt,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_out,
  output logic        out_was_changed,
  output logic        out_char_error
);

  logic          s2_valid_r, s2_valid_nxt;
  vsc_item_t     s2_item_r;
  logic [PW-1:0] s2_kp_r;
  logic [PW-1:0] s2_eff_r;
  logic [PW-1:0] kp_r;
  logic          byp_r;
  logic [7:0]    byp_data_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_changed_r;
  logic          out_error_r;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [7:0]    key_ch;
  logic          key_ok;
  logic          s2_data;
  logic          advance;
  logic [PW:0]   eff_inc;
  logic [PW-1:0] s2_next;
  logic [PW-1:0] kp_after;
  logic [PW-1:0] kp_cur;
  logic [PW-1:0] head_kp;
  logic [PW-1:0] head_eff;
  logic          out_ready;
  logic          s2_go;
  logic          load_out;

  logic [8:0]    d_ofs;
  logic [8:0]    k_ofs;
  logic [9:0]    mod_sum;
  logic [9:0]    mod_res;
  logic [9:0]    code_sum;
  logic [7:0]    cipher_byte;

  vsc_ram #(
    .WIDTH (8),
    .DEPTH (KEY_DEPTH),
    .AW    (PW)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s2_item_r.value),
    .re    (pop),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // key loads write when they leave the read stage
  assign ram_we    = s2_valid_r & s2_item_r.is_key;
  assign ram_waddr = PW'(s2_item_r.slot % KEY_DEPTH);

  assign key_ch  = byp_r ? byp_data_r : ram_rdata;
  assign key_ok  = in_alphabet(key_ch, 8'(FIRST_CHAR), 9'(ALPHABET_SIZE));
  assign s2_data = s2_valid_r & ~s2_item_r.is_key;
  assign advance = s2_data & ~s2_item_r.blank & s2_item_r.byte_ok & key_ok;

  assign eff_inc  = {1'b0, s2_eff_r} + 1'b1;
  assign s2_next  = (eff_inc >= key_len) ? '0 : eff_inc[PW-1:0];
  assign kp_after = advance ? s2_next : s2_kp_r;
  assign kp_cur   = s2_valid_r ? kp_after : kp_r;

  assign out_ready = ~out_valid_r | ~out_stall;
  assign s2_go     = s2_valid_r & (s2_item_r.is_key | out_ready);
  assign pop       = head_valid & (~s2_valid_r | s2_go);
  assign load_out  = s2_go & ~s2_item_r.is_key;

  assign head_kp   = head_item.start ? '0 : kp_cur;
  assign head_eff  = ({1'b0, head_kp} >= key_len) ? '0 : head_kp;
  assign ram_raddr = head_eff;

  // modular add or subtract over the alphabet
  always_comb begin
    d_ofs = {1'b0, s2_item_r.value} - 9'(FIRST_CHAR);
    k_ofs = {1'b0, key_ch} - 9'(FIRST_CHAR);
    if (decrypt) begin
      mod_sum = {1'b0, d_ofs} + 10'(ALPHABET_SIZE) - {1'b0, k_ofs};
    end else begin
      mod_sum = {1'b0, d_ofs} + {1'b0, k_ofs};
    end
    mod_res     = (mod_sum >= 10'(ALPHABET_SIZE)) ? mod_sum - 10'(ALPHABET_SIZE) : mod_sum;
    code_sum    = mod_res + 10'(FIRST_CHAR);
    cipher_byte = code_sum[7:0];
  end

  always_comb begin
    if (pop) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_go) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      kp_r        <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s2_go) begin
        kp_r <= kp_after;
      end
      if (pop) begin
        byp_r <= ram_we && (ram_waddr == ram_raddr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_item_r  <= head_item;
      s2_kp_r    <= head_kp;
      s2_eff_r   <= head_eff;
      byp_data_r <= s2_item_r.value;
    end
    if (load_out) begin
      out_byte_r    <= advance ? cipher_byte : s2_item_r.value;
      out_changed_r <= advance;
      out_error_r   <= ~s2_item_r.blank & ~(s2_item_r.byte_ok & key_ok);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = out_byte_r;
  assign out_was_changed = out_changed_r;
  assign out_char_error  = out_error_r;

endmodule

### src/vigenere_stream_cipher.sv
// vigenere stream cipher top level with configuration registers
// path: a data item passes through the queue, the read stage register and the output register
// throughput: one item per cycle while the output is not stalled; the key position loop closes over the key ram
//   read data, so a data item may follow any item back to back
// reset: clears queue, pipeline, key position and registers (key length 1,
//   encrypt); the key store is not cleared and holds no value until written
module vigenere_stream_cipher
  import vsc_pkg::*;
#(
  parameter int ALPHABET_SIZE = 95,
  parameter int FIRST_CHAR    = 32,
  parameter int KEY_DEPTH     = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [7:0]            in_byte_value,
  input  logic [5:0]            in_key_slot,
  input  logic                  in_message_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte_out,
  output logic                  out_was_changed,
  output logic                  out_char_error,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  logic [KEY_LENGTH_W-1:0] key_length_r;
  logic [PW:0]             eff_len_r;
  logic                    decrypt_r;
  logic [KEY_LENGTH_W-1:0] len_wr;
  logic [PW:0]             eff_len_wr;
  logic                    cfg_wr;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      head_valid;
  vsc_item_t push_item;
  vsc_item_t head_item;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign len_wr = pwdata[KEY_LENGTH_W-1:0];

  always_comb begin
    if (len_wr == '0) begin
      eff_len_wr = (PW+1)'(1);
    end else if (32'(len_wr) > KEY_DEPTH) begin
      eff_len_wr = (PW+1)'(KEY_DEPTH);
    end else begin
      eff_len_wr = (PW+1)'(len_wr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LENGTH_W'(1);
      eff_len_r    <= (PW+1)'(1);
      decrypt_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_KEY_LENGTH: begin
          key_length_r <= len_wr;
          eff_len_r    <= eff_len_wr;
        end
        REG_DECRYPT_MODE: begin
          decrypt_r <= pwdata[0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KEY_LENGTH:   prdata = CFG_DATA_W'(key_length_r);
      REG_DECRYPT_MODE: prdata = CFG_DATA_W'(decrypt_r);
    endcase
  end

  vsc_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .FIRST_CHAR    (FIRST_CHAR)
  ) u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_byte_value    (in_byte_value),
    .in_key_slot      (in_key_slot),
    .in_message_start (in_message_start),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  vsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  vsc_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .FIRST_CHAR    (FIRST_CHAR),
    .KEY_DEPTH     (KEY_DEPTH),
    .PW            (PW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (q_pop),
    .key_len         (eff_len_r),
    .decrypt         (decrypt_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_out    (out_byte_out),
    .out_was_changed (out_was_changed),
    .out_char_error  (out_char_error)
  );

endmodule

### src/vsc_checker.sv
// port level checks for the vigenere stream cipher, bound to the top level
module vsc_port_checks
  import vsc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte_out,
  input logic       out_was_changed,
  input logic       out_char_error
);

  // a stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_out) &&
      $stable(out_was_changed) && $stable(out_char_error))
    else $error("stalled output item changed");

  // reset empties the output
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a ciphered byte never carries an error
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_changed |-> !out_char_error)
    else $error("ciphered byte flagged as error");

  // only space or tab passes unchanged without an error
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_changed && !out_char_error |->
      out_byte_out == CODE_SPACE || out_byte_out == CODE_TAB)
    else $error("unchanged byte without error is not blank");

endmodule

bind vigenere_stream_cipher vsc_port_checks u_vsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte_out    (out_byte_out),
  .out_was_changed (out_was_changed),
  .out_char_error  (out_char_error)
);
